// ===== src/vfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared constants, types and format helpers of the vertex format converter.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int unsigned MAX_TEX_SETS = 8;
  localparam int unsigned VERTEX_WORDS = 30;
  localparam int unsigned IDX_W        = $clog2(VERTEX_WORDS);
  localparam int unsigned FMT_W        = 12;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned SIZE_W       = 6;

  typedef enum logic {
    CFG_DEST_FORMAT = 1'b0,
    CFG_SRC_FORMAT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_SRC  = 2'b00,
    KIND_ZERO = 2'b01,
    KIND_ONES = 2'b10
  } kind_e;

  typedef struct packed {
    logic              err;
    logic [IDX_W-1:0]  eff_words;
    logic [IDX_W-1:0]  dest_words;
  } fmt_info_t;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  src_idx;
  } map_entry_t;

  function automatic logic [3:0] pos_words(input logic [2:0] code);
    logic [3:0] w;
    case (code)
      3'd0:    w = 4'd0;
      3'd1:    w = 4'd3;
      3'd2:    w = 4'd4;
      3'd3:    w = 4'd4;
      3'd4:    w = 4'd5;
      3'd5:    w = 4'd6;
      3'd6:    w = 4'd7;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

  function automatic logic [SIZE_W-1:0] fmt_size(input logic [FMT_W-1:0] f);
    logic [SIZE_W-1:0] s;
    s = {2'b00, pos_words(f[3:1])}
      + (f[4] ? SIZE_W'(3) : SIZE_W'(0))
      + SIZE_W'(f[5]) + SIZE_W'(f[6]) + SIZE_W'(f[7])
      + {1'b0, f[11:8], 1'b0};
    return s;
  endfunction

endpackage

// ===== src/vertex_format_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_format_converter
// Buffers source vertex words and emits them reshaped to the destination
// vertex format through a transfer map.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata: src_word; tlast: batch_end
//  m_axis    out        tdata: dest_word; tlast: vertex_end;
//                       tuser: batch_done, format_error
//  cfg       in         register 0 dest_format, 1 src_format
//
//  A source word is taken and written to the vertex buffer. A completed
//  vertex then emits its n destination words, each through a buffer read,
//  then the output register; input is held off meanwhile. A format error
//  gives one result. Reset clears the counters and format registers; the
//  buffer needs no clearing. Output stalls hold the output register and
//  pause the buffer reads.
// ----------------------------------------------------------------------------
module vertex_format_converter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [vfc_pkg::FMT_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,   // [31:0] src_word
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,   // [31:0] dest_word
  output logic                              m_axis_tlast,
  output logic [1:0]                        m_axis_tuser    // [0] batch_done, [1] format_error
);

  localparam int unsigned IW = vfc_pkg::IDX_W;

  logic [vfc_pkg::FMT_W-1:0] dest_fmt_q, src_fmt_q;
  logic [IW-1:0]             wc_q, wc_d;
  logic                      busy_q, busy_d;
  logic [IW-1:0]             j_q, j_d, n_q, n_d;
  logic                      err_q, err_d, batch_q, batch_d;
  logic                      pend_q;
  vfc_pkg::kind_e            pend_kind_q;
  logic                      pend_last_q, pend_err_q, pend_batch_q;
  logic                      out_valid_q;
  logic [31:0]               out_data_q;
  logic                      out_last_q;
  logic [1:0]                out_user_q;

  vfc_pkg::fmt_info_t        info;
  vfc_pkg::map_entry_t       entry;
  logic [31:0]               rdata;
  logic                      in_xfer, done, issue, last_word;

  vfc_fmt_decode u_decode (
    .dest_fmt_i (dest_fmt_q),
    .src_fmt_i  (src_fmt_q),
    .dest_idx_i (j_q),
    .info_o     (info),
    .entry_o    (entry)
  );

  assign s_axis_tready = !busy_q && !pend_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign done          = ({1'b0, wc_q} + 6'd1) >= {1'b0, info.eff_words};
  assign issue         = busy_q && !pend_q && (!out_valid_q || m_axis_tready);
  assign last_word     = (j_q == n_q - IW'(1));

  vfc_vertex_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && ({27'd0, wc_q} < vfc_pkg::VERTEX_WORDS)),
    .waddr_i (wc_q),
    .wdata_i (s_axis_tdata),
    .re_i    (issue && !err_q && entry.kind == vfc_pkg::KIND_SRC),
    .raddr_i (entry.src_idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_fmt_q <= '0;
      src_fmt_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (vfc_pkg::cfg_idx_e'(cfg_idx_i))
        vfc_pkg::CFG_DEST_FORMAT: dest_fmt_q <= cfg_wdata_i;
        vfc_pkg::CFG_SRC_FORMAT:  src_fmt_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    wc_d    = wc_q;
    busy_d  = busy_q;
    j_d     = j_q;
    n_d     = n_q;
    err_d   = err_q;
    batch_d = batch_q;
    if (in_xfer) begin
      if (done) begin
        wc_d    = '0;
        j_d     = '0;
        err_d   = info.err;
        batch_d = s_axis_tlast;
        n_d     = info.err ? IW'(1) : info.dest_words;
        busy_d  = info.err || (info.dest_words != '0);
      end else begin
        wc_d = wc_q + IW'(1);
      end
      if (s_axis_tlast) wc_d = '0;
    end else if (issue) begin
      j_d = j_q + IW'(1);
      if (last_word) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q    <= '0;
      busy_q  <= 1'b0;
      j_q     <= '0;
      n_q     <= '0;
      err_q   <= 1'b0;
      batch_q <= 1'b0;
    end else begin
      wc_q    <= wc_d;
      busy_q  <= busy_d;
      j_q     <= j_d;
      n_q     <= n_d;
      err_q   <= err_d;
      batch_q <= batch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_kind_q  <= err_q ? vfc_pkg::KIND_ZERO : entry.kind;
      pend_last_q  <= last_word;
      pend_err_q   <= err_q;
      pend_batch_q <= batch_q && last_word;
    end
    if (pend_q) begin
      case (pend_kind_q)
        vfc_pkg::KIND_ZERO: out_data_q <= '0;
        vfc_pkg::KIND_ONES: out_data_q <= '1;
        default:            out_data_q <= rdata;
      endcase
      out_last_q <= pend_last_q;
      out_user_q <= {pend_err_q, pend_batch_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== src/vfc_vertex_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_vertex_ram
// Source vertex buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vfc_vertex_ram (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [vfc_pkg::IDX_W-1:0]         waddr_i,
  input  logic [vfc_pkg::WORD_W-1:0]        wdata_i,
  input  logic                              re_i,
  input  logic [vfc_pkg::IDX_W-1:0]         raddr_i,
  output logic [vfc_pkg::WORD_W-1:0]        rdata_o
);

  logic [vfc_pkg::WORD_W-1:0] mem_q [vfc_pkg::VERTEX_WORDS];
  logic [vfc_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vfc_fmt_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_fmt_decode
// Format pair check, vertex sizes and transfer map entry for one dest word.
// ----------------------------------------------------------------------------
module vfc_fmt_decode (
  input  logic [vfc_pkg::FMT_W-1:0]  dest_fmt_i,
  input  logic [vfc_pkg::FMT_W-1:0]  src_fmt_i,
  input  logic [vfc_pkg::IDX_W-1:0]  dest_idx_i,
  output vfc_pkg::fmt_info_t         info_o,
  output vfc_pkg::map_entry_t        entry_o
);

  localparam int unsigned SW = vfc_pkg::SIZE_W;

  logic [SW-1:0] dsize, ssize, j;
  logic [SW-1:0] b_nrm, b_dif, b_spc, b_tex;
  logic [SW-1:0] o_res, o_nrm, o_dif, o_spc, o_tex;
  logic [SW-1:0] src_sel;

  assign dsize = vfc_pkg::fmt_size(dest_fmt_i);
  assign ssize = vfc_pkg::fmt_size(src_fmt_i);
  assign j     = {1'b0, dest_idx_i};

  always_comb begin
    info_o.err = (dest_fmt_i[3:1] != src_fmt_i[3:1])
              || (dest_fmt_i[4] && !src_fmt_i[4])
              || (dest_fmt_i[11:8] > src_fmt_i[11:8])
              || ({28'd0, dest_fmt_i[11:8]} > vfc_pkg::MAX_TEX_SETS)
              || ({28'd0, src_fmt_i[11:8]} > vfc_pkg::MAX_TEX_SETS)
              || ({26'd0, dsize} > vfc_pkg::VERTEX_WORDS)
              || ({26'd0, ssize} > vfc_pkg::VERTEX_WORDS)
              || (ssize == '0);
    if ({26'd0, ssize} > vfc_pkg::VERTEX_WORDS) begin
      info_o.eff_words = vfc_pkg::IDX_W'(vfc_pkg::VERTEX_WORDS);
    end else if (ssize == '0) begin
      info_o.eff_words = vfc_pkg::IDX_W'(1);
    end else begin
      info_o.eff_words = ssize[vfc_pkg::IDX_W-1:0];
    end
    info_o.dest_words = dsize[vfc_pkg::IDX_W-1:0];
  end

  always_comb begin
    b_nrm = {2'b00, vfc_pkg::pos_words(dest_fmt_i[3:1])} + SW'(dest_fmt_i[5]);
    b_dif = b_nrm + (dest_fmt_i[4] ? SW'(3) : SW'(0));
    b_spc = b_dif + SW'(dest_fmt_i[6]);
    b_tex = b_spc + SW'(dest_fmt_i[7]);

    o_res = {2'b00, vfc_pkg::pos_words(src_fmt_i[3:1])};
    o_nrm = o_res + SW'(src_fmt_i[5]);
    o_dif = o_nrm + (src_fmt_i[4] ? SW'(3) : SW'(0));
    o_spc = o_dif + SW'(src_fmt_i[6]);
    o_tex = o_spc + SW'(src_fmt_i[7]);

    entry_o.kind = vfc_pkg::KIND_SRC;
    src_sel      = j;
    if (j < o_res && j < {2'b00, vfc_pkg::pos_words(dest_fmt_i[3:1])}) begin
      src_sel = j;
    end else if (j < b_nrm) begin
      src_sel = o_res;
      if (!src_fmt_i[5]) entry_o.kind = vfc_pkg::KIND_ZERO;
    end else if (j < b_dif) begin
      src_sel = o_nrm + (j - b_nrm);
    end else if (j < b_spc) begin
      src_sel = o_dif;
      if (!src_fmt_i[6]) entry_o.kind = vfc_pkg::KIND_ONES;
    end else if (j < b_tex) begin
      src_sel = o_spc;
      if (!src_fmt_i[7]) entry_o.kind = vfc_pkg::KIND_ONES;
    end else begin
      src_sel = o_tex + (j - b_tex);
    end
    entry_o.src_idx = src_sel[vfc_pkg::IDX_W-1:0];
  end

endmodule

// ===== verif/vertex_format_converter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_format_converter_checker
// Watches the configuration port and both stream channels of the vertex
// format converter. Keeps its own copy of the format registers, the vertex
// buffer and the word counter, works out the destination words that each
// accepted source word causes, and compares every output transfer field by
// field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module vertex_format_converter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [31:0] src_word
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,    // [31:0] dest_word
  input  logic        m_axis_tlast,
  input  logic [1:0]  m_axis_tuser,    // [0] batch_done, [1] format_error
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          error_results
);
  import vfc_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic        vertex_end;
    logic        batch_done;
    logic        format_error;
  } dest_beat_t;

  logic [11:0] dest_fmt;
  logic [11:0] src_fmt;
  logic [31:0] vtx_buf [VERTEX_WORDS];
  int          word_cnt;
  dest_beat_t  words_due [$];
  int          mismatches;
  int          n_results;
  int          n_err_results;

  function automatic int position_len(input logic [2:0] code);
    case (code)
      3'd0:    return 0;
      3'd1:    return 3;
      3'd2:    return 4;
      3'd3:    return 4;
      3'd4:    return 5;
      3'd5:    return 6;
      3'd6:    return 7;
      default: return 8;
    endcase
  endfunction

  function automatic int fmt_words(input logic [11:0] f);
    return position_len(f[3:1]) + 3 * int'(f[4]) + int'(f[5]) + int'(f[6])
         + int'(f[7]) + 2 * int'(f[11:8]);
  endfunction

  function automatic bit pair_unconvertible(input logic [11:0] d, input logic [11:0] s);
    return (d[3:1] != s[3:1]) || (d[4] && !s[4]) || (d[11:8] > s[11:8])
        || (int'(d[11:8]) > MAX_TEX_SETS) || (int'(s[11:8]) > MAX_TEX_SETS)
        || (fmt_words(d) > VERTEX_WORDS) || (fmt_words(s) > VERTEX_WORDS)
        || (fmt_words(s) == 0);
  endfunction

  task automatic push_word(input logic [31:0] v);
    dest_beat_t beat;
    beat = '{word: v, vertex_end: 1'b0, batch_done: 1'b0, format_error: 1'b0};
    words_due.push_back(beat);
  endtask

  task automatic emit_dest_vertex();
    int         si;
    int         i;
    int         prior_size;
    dest_beat_t beat;
    si = 0;
    prior_size = words_due.size();
    for (i = 0; i < position_len(dest_fmt[3:1]); i++) begin
      push_word(vtx_buf[si]);
      si++;
    end
    if (dest_fmt[5]) begin
      if (src_fmt[5]) begin
        push_word(vtx_buf[si]);
        si++;
      end else begin
        push_word('0);
      end
    end else if (src_fmt[5]) begin
      si++;
    end
    if (dest_fmt[4]) begin
      for (i = 0; i < 3; i++) begin
        push_word(vtx_buf[si]);
        si++;
      end
    end else if (src_fmt[4]) begin
      si += 3;
    end
    if (dest_fmt[6]) begin
      if (src_fmt[6]) begin
        push_word(vtx_buf[si]);
        si++;
      end else begin
        push_word('1);
      end
    end else if (src_fmt[6]) begin
      si++;
    end
    if (dest_fmt[7]) begin
      if (src_fmt[7]) begin
        push_word(vtx_buf[si]);
        si++;
      end else begin
        push_word('1);
      end
    end else if (src_fmt[7]) begin
      si++;
    end
    for (i = 0; i < 2 * int'(dest_fmt[11:8]); i++) begin
      push_word(vtx_buf[si]);
      si++;
    end
    if (words_due.size() > prior_size) begin
      beat = words_due.pop_back();
      beat.vertex_end = 1'b1;
      words_due.push_back(beat);
    end
  endtask

  task automatic convert_source_word(input logic [31:0] w, input logic batch_end);
    int         eff;
    int         prior_size;
    dest_beat_t beat;
    eff = fmt_words(src_fmt);
    if (eff > VERTEX_WORDS) eff = VERTEX_WORDS;
    if (eff == 0) eff = 1;
    prior_size = words_due.size();
    if (word_cnt < VERTEX_WORDS) vtx_buf[word_cnt] = w;
    if (word_cnt + 1 >= eff) begin
      if (pair_unconvertible(dest_fmt, src_fmt)) begin
        beat = '{word: '0, vertex_end: 1'b1, batch_done: 1'b0, format_error: 1'b1};
        words_due.push_back(beat);
      end else begin
        emit_dest_vertex();
      end
      word_cnt = 0;
    end else begin
      word_cnt++;
    end
    if (batch_end) begin
      word_cnt = 0;
      if (words_due.size() > prior_size) begin
        beat = words_due.pop_back();
        beat.batch_done = 1'b1;
        words_due.push_back(beat);
      end
    end
  endtask

  task automatic check_result();
    dest_beat_t want;
    if (words_due.size() == 0) begin
      $error("unexpected result: dest_word %h vertex_end %b tuser %b",
             m_axis_tdata, m_axis_tlast, m_axis_tuser);
      mismatches++;
    end else begin
      want = words_due.pop_front();
      if (m_axis_tdata !== want.word) begin
        $error("dest_word: expected %h, got %h", want.word, m_axis_tdata);
        mismatches++;
      end
      if (m_axis_tlast !== want.vertex_end) begin
        $error("vertex_end: expected %b, got %b", want.vertex_end, m_axis_tlast);
        mismatches++;
      end
      if (m_axis_tuser[0] !== want.batch_done) begin
        $error("batch_done: expected %b, got %b", want.batch_done, m_axis_tuser[0]);
        mismatches++;
      end
      if (m_axis_tuser[1] !== want.format_error) begin
        $error("format_error: expected %b, got %b", want.format_error, m_axis_tuser[1]);
        mismatches++;
      end
      n_results++;
      if (want.format_error) n_err_results++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_fmt = '0;
      src_fmt = '0;
      word_cnt = 0;
      words_due.delete();
      mismatches = 0;
      n_results = 0;
      n_err_results = 0;
      fail_count <= 0;
      pending <= 0;
      results_seen <= 0;
      error_results <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DEST_FORMAT) dest_fmt = cfg_wdata_i;
        else src_fmt = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) convert_source_word(s_axis_tdata, s_axis_tlast);
      fail_count <= mismatches;
      pending <= words_due.size();
      results_seen <= n_results;
      error_results <= n_err_results;
    end
  end

endmodule

// ===== verif/vertex_format_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_format_converter_tb
// Drives the vertex format converter with directed format pairs (equal
// formats, fills, skipped fields, dropped texture sets, a zero-sized source
// as a format error, empty destination, batch end inside a vertex, format change inside
// a vertex) and then with random pairs and vertex streams under changing
// idle patterns and a long output hold-off. A separate checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module vertex_format_converter_tb;
  import vfc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_WORDS  = 70;
  localparam int HOLD_CYCLES   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [31:0] src_word
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] dest_word
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;         // [0] batch_done, [1] format_error

  int fail_count;
  int pending;
  int results_seen;
  int error_results;
  int src_idle_pct = 6;
  int snk_idle_pct = 74;
  int hold_req = 0;
  int hold_left = 0;
  int words_sent = 0;
  int settings = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  vertex_format_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  vertex_format_converter_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .error_results (error_results)
  );

  // hold off for a requested stretch, else stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk_i);
    $display("FAIL vertex_format_converter");
    $finish;
  end

  // source words per vertex, as the block counts them
  function automatic int vertex_len(input logic [11:0] f);
    int n;
    case (f[3:1])
      3'd0:    n = 0;
      3'd1:    n = 3;
      3'd2:    n = 4;
      3'd3:    n = 4;
      3'd4:    n = 5;
      3'd5:    n = 6;
      3'd6:    n = 7;
      default: n = 8;
    endcase
    n += 3 * int'(f[4]) + int'(f[5]) + int'(f[6]) + int'(f[7]) + 2 * int'(f[11:8]);
    if (n > 30) n = 30;
    if (n == 0) n = 1;
    return n;
  endfunction

  task automatic set_formats(input logic [11:0] d, input logic [11:0] s);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_DEST_FORMAT;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SRC_FORMAT;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic offer(input logic [31:0] w, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic push_run(input int n, input bit close);
    int          r;
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(7);
      w = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom;
      offer(w, close && (i == n - 1));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic pick_pair(input bit bad, input bit big,
                           output logic [11:0] d, output logic [11:0] s);
    logic [3:0] ts;
    logic [3:0] td;
    ts = big ? 4'd8 : 4'($urandom_range(2));
    s = {ts, 4'($urandom), 3'($urandom), 1'($urandom)};
    if (big) s = {4'd8, 4'hf, 3'd7, 1'($urandom)};
    if (s[11:1] == '0) s[6] = 1'b1;
    td = 4'($urandom_range(ts));
    d = {td, 1'($urandom), 1'($urandom), 1'($urandom), s[4] & 1'($urandom), s[3:1],
         1'($urandom)};
    if (bad) begin
      case ($urandom_range(5))
        0: d[3:1] = s[3:1] + 3'd1;
        1: begin
          s[4] = 1'b0;
          d[4] = 1'b1;
        end
        2: d[11:8] = s[11:8] + 4'd1;
        3: s[11:8] = 4'($urandom_range(15, 9));
        4: s = {11'd0, 1'($urandom)};
        default: begin
          d = 12'($urandom);
          s = 12'($urandom);
        end
      endcase
    end
  endtask

  initial begin
    logic [11:0] d;
    logic [11:0] s;
    int          phase;
    int          base;
    int          eff;
    int          carry;
    int          len;
    int          nv;
    int          r;
    bit          bad;
    bit          big;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // equal formats
    set_formats(12'h102, 12'h102);
    push_run(5, 1'b0);
    drain();
    // missing reserved, diffuse and specular
    set_formats(12'h0e2, 12'h002);
    push_run(3, 1'b1);
    drain();
    // skip normal and reserved, drop a texture set
    set_formats(12'h100, 12'h230);
    push_run(8, 1'b0);
    drain();
    // zero-sized source
    set_formats(12'h000, 12'h000);
    push_run(2, 1'b1);
    drain();
    set_formats(12'hfff, 12'h000);
    push_run(1, 1'b0);
    drain();
    // batch end inside a vertex
    set_formats(12'hfff, 12'hfff);
    push_run(3, 1'b1);
    drain();
    // empty destination
    set_formats(12'h000, 12'h040);
    push_run(1, 1'b0);
    drain();
    // format change inside a vertex
    set_formats(12'h002, 12'h002);
    push_run(2, 1'b0);
    drain();
    set_formats(12'h040, 12'h040);
    push_run(1, 1'b0);
    drain();

    base = words_sent;
    phase = 0;
    carry = 0;
    while (words_sent - base < RANDOM_WORDS) begin
      if (words_sent - base < RANDOM_WORDS / 3) begin
        src_idle_pct = 6;
        snk_idle_pct = 74;
      end else if (words_sent - base < 2 * RANDOM_WORDS / 3) begin
        src_idle_pct = 74;
        snk_idle_pct = 6;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      bad = (phase != 2) && ($urandom_range(99) < 20);
      big = !bad && (phase != 2) && ($urandom_range(99) < 8);
      pick_pair(bad, big, d, s);
      // keep the destination non-empty so the hold-off backs up the block
      if (phase == 2) d[6] = 1'b1;
      set_formats(d, s);
      eff = vertex_len(s);
      if (phase == 2) hold_req = HOLD_CYCLES;
      nv = big ? 1 : $urandom_range(4, 1);
      for (int v = 0; v < nv; v++) begin
        len = (carry >= eff) ? 1 : eff - carry;
        carry = 0;
        r = $urandom_range(99);
        if (r < 8 && len > 1) push_run($urandom_range(len - 1, 1), 1'b1);
        else push_run(len, r < 33);
      end
      // leave a partial vertex for the next format pair
      if (eff > 1 && $urandom_range(99) < 15) begin
        carry = $urandom_range(eff - 1, 1);
        push_run(carry, 1'b0);
      end
      drain();
      phase++;
    end

    $display("Covered %0d source words under %0d format settings: fills, skips, drops,",
             words_sent, settings);
    $display("format errors, batch ends and mid-vertex changes; %0d results, %0d errors",
             results_seen, error_results);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS vertex_format_converter");
    end else begin
      $display("FAIL vertex_format_converter");
    end
    $finish;
  end

endmodule
